FILE: sv/cpp2d_pkg.sv
package cpp2d_pkg;

   localparam int FIELD_BITS = 16;
   localparam int DIST_BITS  = 33;
   // widest stored coordinate: a 16-bit field taken as unsigned
   localparam int EXT_BITS   = FIELD_BITS + 1;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] coord_x;
      logic signed [FIELD_BITS-1:0] coord_y;
      logic                         last_point;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] first_x;
      logic signed [FIELD_BITS-1:0] first_y;
      logic signed [FIELD_BITS-1:0] second_x;
      logic signed [FIELD_BITS-1:0] second_y;
      logic        [DIST_BITS-1:0]  squared_distance;
      logic                         found;
      logic                         overflowed;
   } rsp_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   typedef struct packed {
      logic load;
      logic pair_go;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic iter_done;
      logic pipe_busy;
   } dp_status_type;

endpackage

FILE: sv/cpp2d_ctrl.sv
module cpp2d_ctrl import cpp2d_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          last_point,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.pair_go = 1'b0;
      cmd.finish  = 1'b0;
      busy        = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
            if (start && last_point) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.pair_go = !status.iter_done;
            // wait for the last pair to leave the pipeline
            if (status.iter_done && !status.pipe_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/cpp2d_dp.sv
module cpp2d_dp import cpp2d_pkg::*; #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   input  req_type       req_data,
   output dp_status_type status,
   output rsp_type       rsp_data,
   output logic          rsp_strobe
);

   localparam int SW   = (COORD_BITS > FIELD_BITS) ? EXT_BITS : COORD_BITS;
   localparam int TAKE = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
   localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW   = $clog2(MAX_POINTS + 2);
   localparam int QW   = 2 * SW;
   localparam int DW   = QW + 1;

   typedef struct packed {
      logic signed [SW-1:0] x;
      logic signed [SW-1:0] y;
   } point_type;

   function automatic logic signed [SW-1:0] take_coord(input logic [FIELD_BITS-1:0] raw);
      logic signed [EXT_BITS-1:0] ext;
      if (COORD_BITS > FIELD_BITS) begin
         ext = EXT_BITS'({1'b0, raw});
      end else begin
         ext = EXT_BITS'(signed'(raw[TAKE-1:0]));
      end
      return ext[SW-1:0];
   endfunction

   function automatic logic [SW-1:0] abs_diff(input logic signed [SW-1:0] a,
                                              input logic signed [SW-1:0] b);
      logic signed [SW:0] d;
      d = (SW+1)'(a) - (SW+1)'(b);
      if (d < 0) begin
         d = -d;
      end
      return d[SW-1:0];
   endfunction

   point_type mem_ff [MAX_POINTS];

   logic [CW-1:0] count_ff, count_in;
   logic          overflow_ff, overflow_in;
   logic [CW-1:0] pi_ff, pi_in;
   logic [CW-1:0] pj_ff, pj_in;

   // pipeline: read, abs difference, square, compare
   logic          v0_ff, v1_ff, v2_ff;
   point_type     rd_a_ff, rd_b_ff;
   point_type     s1_a_ff, s1_b_ff;
   logic [SW-1:0] dx_ff, dy_ff;
   point_type     s2_a_ff, s2_b_ff;
   logic [QW-1:0] qx_ff, qy_ff;

   logic          best_valid_ff;
   logic [DW-1:0] best_d_ff;
   point_type     best_a_ff, best_b_ff;
   logic [DW-1:0] sum;

   rsp_type       rsp_ff;
   logic          rsp_strobe_ff;

   assign status.iter_done = (pj_ff >= count_ff);
   assign status.pipe_busy = v0_ff | v1_ff | v2_ff;
   assign rsp_data   = rsp_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign sum = DW'(qx_ff) + DW'(qy_ff);

   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < CW'(MAX_POINTS))) begin
         mem_ff[count_ff[AW-1:0]] <= '{x: take_coord(req_data.coord_x),
                                       y: take_coord(req_data.coord_y)};
      end
      rd_a_ff <= mem_ff[pi_ff[AW-1:0]];
      rd_b_ff <= mem_ff[pj_ff[AW-1:0]];
   end

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      pi_in       = pi_ff;
      pj_in       = pj_ff;
      if (cmd.load) begin
         if (count_ff < CW'(MAX_POINTS)) begin
            count_in = count_ff + CW'(1);
         end else begin
            overflow_in = 1'b1;
         end
         pi_in = '0;
         pj_in = CW'(1);
      end else if (cmd.pair_go) begin
         if ((pj_ff + CW'(1)) < count_ff) begin
            pj_in = pj_ff + CW'(1);
         end else begin
            pi_in = pi_ff + CW'(1);
            pj_in = pi_ff + CW'(2);
         end
      end
      if (cmd.finish) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         pi_ff         <= '0;
         pj_ff         <= CW'(1);
         v0_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         overflow_ff   <= overflow_in;
         pi_ff         <= pi_in;
         pj_ff         <= pj_in;
         v0_ff         <= cmd.pair_go;
         v1_ff         <= v0_ff;
         v2_ff         <= v1_ff;
         rsp_strobe_ff <= cmd.finish;
         if (cmd.finish) begin
            best_valid_ff <= 1'b0;
         end else if (v2_ff && (!best_valid_ff || (sum < best_d_ff))) begin
            best_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_a_ff <= rd_a_ff;
      s1_b_ff <= rd_b_ff;
      dx_ff   <= abs_diff(rd_a_ff.x, rd_b_ff.x);
      dy_ff   <= abs_diff(rd_a_ff.y, rd_b_ff.y);
      s2_a_ff <= s1_a_ff;
      s2_b_ff <= s1_b_ff;
      qx_ff   <= dx_ff * dx_ff;
      qy_ff   <= dy_ff * dy_ff;
      // strict less keeps the earliest pair on a tie
      if (v2_ff && (!best_valid_ff || (sum < best_d_ff))) begin
         best_d_ff <= sum;
         best_a_ff <= s2_a_ff;
         best_b_ff <= s2_b_ff;
      end
      if (cmd.finish) begin
         rsp_ff.overflowed <= overflow_ff;
         if (count_ff >= CW'(2)) begin
            rsp_ff.found            <= 1'b1;
            rsp_ff.first_x          <= FIELD_BITS'(best_a_ff.x);
            rsp_ff.first_y          <= FIELD_BITS'(best_a_ff.y);
            rsp_ff.second_x         <= FIELD_BITS'(best_b_ff.x);
            rsp_ff.second_y         <= FIELD_BITS'(best_b_ff.y);
            rsp_ff.squared_distance <= DIST_BITS'(best_d_ff);
         end else begin
            rsp_ff.found            <= 1'b0;
            rsp_ff.first_x          <= '0;
            rsp_ff.first_y          <= '0;
            rsp_ff.second_x         <= '0;
            rsp_ff.second_y         <= '0;
            rsp_ff.squared_distance <= '0;
         end
      end
   end

endmodule

FILE: sv/closest_point_pair_2d.sv
// Loading: one point request per cycle while busy is low.
// Search: one pair per cycle through a four-stage read/abs/square/compare pipeline;
// busy stays high until the result strobe, which follows once the last pair leaves it.
// The receiver cannot stall: rsp_strobe is high for exactly one cycle per set.
// Synchronous reset empties the set; the point memory itself is not cleared.
module closest_point_pair_2d import cpp2d_pkg::*; #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   cpp2d_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .last_point (req_data.last_point),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   cpp2d_dp #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .status     (status),
      .rsp_data   (rsp_data),
      .rsp_strobe (rsp_strobe)
   );

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_strobe)
      else $error("search ended without a result");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result while busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result repeated");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.last_point) |=> busy)
      else $error("last point did not start a search");

endmodule
